### sv/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants of the stepper ramp profile generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam int unsigned LEN_BITS       = 12;
  localparam int unsigned CFG_ADDR_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_RAMP_LENGTH = 2'd0;
  localparam logic [LEN_BITS-1:0]      RAMP_LENGTH_RST = 12'd1600;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [10:0] table_index;
    logic [15:0] table_value;
    logic [23:0] pulse_count;
  } req_t;

  typedef struct packed {
    logic [15:0] step_period;
    logic        last_step;
    logic        move_done;
  } rsp_t;

  typedef struct packed {
    logic use_mem;
    logic last_step;
    logic move_done;
  } step_t;

endpackage

### sv/srpg_table.sv
// ----------------------------------------------------------------------------
// srpg_table
// Ramp period table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srpg_table #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/srpg_seq.sv
// ----------------------------------------------------------------------------
// srpg_seq
// Move sequencer: phase, ramp position and cruise count, table addressing.
// ----------------------------------------------------------------------------
module srpg_seq #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned AW          = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  srpg_pkg::req_t                req_i,
  input  logic [srpg_pkg::LEN_BITS-1:0] ramp_length_i,
  output logic                          step_valid_o,
  output srpg_pkg::step_t               step_o,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [PERIOD_BITS-1:0]        wdata_o,
  output logic                          re_o,
  output logic [AW-1:0]                 raddr_o
);

  localparam int unsigned PW = AW + 1;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CLIMB   = 2'd1;
  localparam logic [1:0] PH_CRUISE  = 2'd2;
  localparam logic [1:0] PH_DESCEND = 2'd3;

  logic [1:0]            phase_q, phase_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [PW-1:0]         climb_q, climb_d;
  logic [COUNT_BITS-1:0] cruise_q, cruise_d;
  logic [COUNT_BITS-1:0] count;
  logic [PW-1:0]         len;
  logic [PW-1:0]         desc_pos;
  logic [PW-1:0]         desc_next;
  logic [33:0]           count_w;
  logic [33:0]           twice_w;

  always_comb begin
    if (ramp_length_i == '0) begin
      len = PW'(1);
    end else if (32'(ramp_length_i) > TABLE_DEPTH) begin
      len = PW'(TABLE_DEPTH);
    end else begin
      len = PW'(ramp_length_i);
    end
  end

  assign count     = COUNT_BITS'(32'(req_i.pulse_count));
  assign count_w   = 34'(count);
  assign twice_w   = 34'(len) << 1;
  assign desc_pos  = (phase_q == PH_DESCEND) ? pos_q : climb_q;
  assign desc_next = desc_pos - PW'(1);

  assign we_o    = accept_i && (req_i.cmd == srpg_pkg::CMD_WRITE) &&
                   (32'(req_i.table_index) < TABLE_DEPTH);
  assign waddr_o = AW'(32'(req_i.table_index));
  assign wdata_o = PERIOD_BITS'(32'(req_i.table_value));

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    climb_d      = climb_q;
    cruise_d     = cruise_q;
    step_valid_o = 1'b0;
    step_o       = '0;
    re_o         = 1'b0;
    raddr_o      = '0;
    if (accept_i) begin
      case (req_i.cmd)
        srpg_pkg::CMD_START: begin
          step_valid_o = 1'b1;
          if (count == '0) begin
            phase_d          = PH_IDLE;
            step_o.move_done = 1'b1;
          end else begin
            re_o           = 1'b1;
            step_o.use_mem = 1'b1;
            if (count_w >= twice_w) begin
              climb_d  = len;
              cruise_d = COUNT_BITS'(count_w - twice_w);
            end else begin
              climb_d  = PW'(count >> 1);
              cruise_d = COUNT_BITS'(count[0]);
            end
            if (count == COUNT_BITS'(1)) begin
              // single step uses the first entry
              phase_d          = PH_CRUISE;
              cruise_d         = '0;
              pos_d            = '0;
              step_o.last_step = 1'b1;
            end else begin
              phase_d = PH_CLIMB;
              pos_d   = PW'(1);
            end
          end
        end
        srpg_pkg::CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            step_valid_o = 1'b1;
            if (phase_q == PH_CLIMB && pos_q < climb_q) begin
              re_o           = 1'b1;
              raddr_o        = pos_q[AW-1:0];
              step_o.use_mem = 1'b1;
              pos_d          = pos_q + PW'(1);
            end else if (phase_q != PH_DESCEND && cruise_q != '0) begin
              phase_d          = PH_CRUISE;
              cruise_d         = cruise_q - COUNT_BITS'(1);
              step_o.last_step = (cruise_q == COUNT_BITS'(1)) && (climb_q == '0);
            end else if (desc_pos != '0) begin
              phase_d          = PH_DESCEND;
              pos_d            = desc_next;
              re_o             = 1'b1;
              raddr_o          = desc_next[AW-1:0];
              step_o.use_mem   = 1'b1;
              step_o.last_step = (desc_next == '0);
            end else begin
              phase_d          = PH_IDLE;
              step_o.move_done = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      climb_q  <= '0;
      cruise_q <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      climb_q  <= climb_d;
      cruise_q <= cruise_d;
    end
  end

endmodule

### sv/srpg_out.sv
// ----------------------------------------------------------------------------
// srpg_out
// Period select stage and output register; holds the current period.
// ----------------------------------------------------------------------------
module srpg_out #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_valid_i,
  input  srpg_pkg::step_t        step_i,
  input  logic [PERIOD_BITS-1:0] rdata_i,
  output logic                   stall_o,
  output logic                   out_valid_o,
  output srpg_pkg::rsp_t         out_rsp_o,
  input  logic                   out_stall_i
);

  logic                   s1_valid_q;
  srpg_pkg::step_t        s1_step_q;
  logic                   out_valid_q;
  srpg_pkg::rsp_t         out_rsp_q;
  logic [PERIOD_BITS-1:0] cur_period_q;
  logic [PERIOD_BITS-1:0] period;
  logic                   out_free;
  logic                   s1_move;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_move  = s1_valid_q && out_free;
  assign stall_o  = s1_valid_q && !out_free;
  assign period   = s1_step_q.use_mem ? rdata_i : cur_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_period_q <= '0;
    end else begin
      if (!stall_o) begin
        s1_valid_q <= step_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move && s1_step_q.use_mem) begin
        cur_period_q <= rdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_valid_i && !stall_o) begin
      s1_step_q <= step_i;
    end
    if (s1_move) begin
      out_rsp_q.step_period <= s1_step_q.move_done ? 16'd0 : 16'(32'(period));
      out_rsp_q.last_step   <= s1_step_q.last_step;
      out_rsp_q.move_done   <= s1_step_q.move_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### sv/stepper_ramp_profile_generator_core.sv
// path: a request goes through the select stage register, then the output register
// throughput: one request per cycle unless stalled, set by the one table read port
// stall: in_stall_o rises only while the output register is full and stalled
// reset: move state idle, ramp_length 1600, table contents undefined until written
// ----------------------------------------------------------------------------
// stepper_ramp_profile_generator_core
// Step-period sequencer for one stepper move from a loaded ramp table.
// ----------------------------------------------------------------------------
module stepper_ramp_profile_generator_core #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned PERIOD_BITS = 16,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  srpg_pkg::req_t                     in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output srpg_pkg::rsp_t                     out_rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srpg_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [srpg_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [srpg_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [srpg_pkg::LEN_BITS-1:0] ramp_length_q;
  logic                          accept;
  logic                          step_valid;
  srpg_pkg::step_t               step;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [PERIOD_BITS-1:0]        wdata;
  logic                          re;
  logic [AW-1:0]                 raddr;
  logic [PERIOD_BITS-1:0]        rdata;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == srpg_pkg::REG_RAMP_LENGTH) ?
                  srpg_pkg::CFG_DATA_BITS'(ramp_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_length_q <= srpg_pkg::RAMP_LENGTH_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == srpg_pkg::REG_RAMP_LENGTH)) begin
      ramp_length_q <= pwdata[srpg_pkg::LEN_BITS-1:0];
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  srpg_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PERIOD_BITS (PERIOD_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .AW          (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_i         (in_req_i),
    .ramp_length_i (ramp_length_q),
    .step_valid_o  (step_valid),
    .step_o        (step),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_o       (raddr)
  );

  srpg_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (PERIOD_BITS),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  srpg_out #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_valid),
    .step_i       (step),
    .rdata_i      (rdata),
    .stall_o      (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_rsp_o    (out_rsp_o),
    .out_stall_i  (out_stall_i)
  );

`ifndef SYNTHESIS
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.move_done |->
      out_rsp_o.step_period == '0 && !out_rsp_o.last_step)
    else $error("move done request carries step data");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");
`endif

endmodule

### test/srpg_profile_checker.sv
// ----------------------------------------------------------------------------
// srpg_profile_checker
// Watches the request, result and register ports of the ramp profile
// generator, keeps its own copy of the period table and move state, predicts
// the result of each accepted start or in-move tick, compares each accepted
// result field by field with the oldest prediction and checks register reads.
// ----------------------------------------------------------------------------
module srpg_profile_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  srpg_pkg::req_t                       in_req_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  srpg_pkg::rsp_t                       out_rsp_i,
  input  logic                                 psel_i,
  input  logic                                 penable_i,
  input  logic                                 pwrite_i,
  input  logic [srpg_pkg::CFG_ADDR_BITS-1:0]   paddr_i,
  input  logic [srpg_pkg::CFG_DATA_BITS-1:0]   pwdata_i,
  input  logic [srpg_pkg::CFG_DATA_BITS-1:0]   prdata_i,
  input  logic                                 pready_i,
  output int unsigned                          pending_o,
  output int unsigned                          errors_o
);

  localparam int unsigned DEPTH = 2048;

  typedef enum logic [1:0] {
    MV_IDLE,
    MV_CLIMB,
    MV_CRUISE,
    MV_DESCEND
  } move_phase_e;

  logic [15:0]                   period_table [DEPTH];
  logic [srpg_pkg::LEN_BITS-1:0] ramp_len_reg;
  move_phase_e                   move_phase;
  logic [11:0]                   ramp_pos;
  logic [11:0]                   climb_lim;
  logic [23:0]                   cruise_left;
  logic [15:0]                   cur_period;
  srpg_pkg::rsp_t                next_rsp;
  srpg_pkg::rsp_t                want;
  srpg_pkg::rsp_t                expected_steps [$];
  int unsigned                   mismatches;
  int unsigned                   waiting;

  assign pending_o = waiting;
  assign errors_o  = mismatches;

  task automatic flag(input string what, input logic [31:0] exp_val, input logic [31:0] act_val);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, act_val);
    mismatches++;
  endtask

  // next step of the running move, or the done report once it is over
  task automatic advance_move();
    next_rsp = '0;
    if (move_phase == MV_CLIMB) begin
      if (ramp_pos < climb_lim) begin
        cur_period = period_table[ramp_pos[10:0]];
        ramp_pos++;
        next_rsp.step_period = cur_period;
        return;
      end
      move_phase = MV_CRUISE;
    end
    if (move_phase == MV_CRUISE) begin
      if (cruise_left != '0) begin
        cruise_left--;
        next_rsp.step_period = cur_period;
        next_rsp.last_step   = (cruise_left == '0) && (climb_lim == '0);
        return;
      end
      move_phase = MV_DESCEND;
      ramp_pos   = climb_lim;
    end
    if (move_phase == MV_DESCEND && ramp_pos != '0) begin
      ramp_pos--;
      cur_period = period_table[ramp_pos[10:0]];
      next_rsp.step_period = cur_period;
      next_rsp.last_step   = (ramp_pos == '0);
      return;
    end
    move_phase = MV_IDLE;
    next_rsp.move_done = 1'b1;
  endtask

  task automatic launch_move(input logic [23:0] count);
    int unsigned len;
    len = (ramp_len_reg == '0) ? 1 : ((ramp_len_reg > DEPTH) ? DEPTH : int'(ramp_len_reg));
    if (count == '0) begin
      move_phase = MV_IDLE;
      next_rsp = '0;
      next_rsp.move_done = 1'b1;
      return;
    end
    if (count >= 2 * len) begin
      climb_lim   = 12'(len);
      cruise_left = count - 24'(2 * len);
    end else begin
      climb_lim   = 12'(count >> 1);
      cruise_left = {23'b0, count[0]};
    end
    if (climb_lim == '0) cur_period = period_table[0];
    ramp_pos   = '0;
    move_phase = MV_CLIMB;
    advance_move();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_len_reg = srpg_pkg::RAMP_LENGTH_RST;
      move_phase   = MV_IDLE;
      ramp_pos     = '0;
      climb_lim    = '0;
      cruise_left  = '0;
      cur_period   = '0;
      mismatches   = 0;
      expected_steps.delete();
      waiting      = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == srpg_pkg::REG_RAMP_LENGTH) begin
        if (pwrite_i) begin
          ramp_len_reg = pwdata_i[srpg_pkg::LEN_BITS-1:0];
        end else if (prdata_i !== srpg_pkg::CFG_DATA_BITS'(ramp_len_reg)) begin
          flag("ramp_length read", srpg_pkg::CFG_DATA_BITS'(ramp_len_reg), prdata_i);
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_steps.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_rsp_i);
          mismatches++;
        end else begin
          want = expected_steps.pop_front();
          if (out_rsp_i.step_period !== want.step_period)
            flag("step_period", 32'(want.step_period), 32'(out_rsp_i.step_period));
          if (out_rsp_i.last_step !== want.last_step)
            flag("last_step", 32'(want.last_step), 32'(out_rsp_i.last_step));
          if (out_rsp_i.move_done !== want.move_done)
            flag("move_done", 32'(want.move_done), 32'(out_rsp_i.move_done));
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (in_req_i.cmd)
          srpg_pkg::CMD_WRITE: period_table[in_req_i.table_index] = in_req_i.table_value;
          srpg_pkg::CMD_START: begin
            launch_move(in_req_i.pulse_count);
            expected_steps.push_back(next_rsp);
          end
          srpg_pkg::CMD_TICK: begin
            if (move_phase != MV_IDLE) begin
              advance_move();
              expected_steps.push_back(next_rsp);
            end
          end
          default: ;
        endcase
      end
      waiting = expected_steps.size();
    end
  end

endmodule

### test/stepper_ramp_profile_generator_core_test.sv
// ----------------------------------------------------------------------------
// stepper_ramp_profile_generator_core_test
// Loads a ramp table, runs directed moves (zero and one step counts, short
// odd and even moves, a restart during a move, idle ticks, the unused
// command), then random move sequences with table rewrites, aborted moves and
// noise under several ramp lengths, the extremes included. Both sides pause
// at random; the result side holds off for long stretches now and then.
// ----------------------------------------------------------------------------
module stepper_ramp_profile_generator_core_test;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned PRELOAD     = 128;
  localparam int unsigned PHASE_ITEMS = 55;
  localparam int unsigned SETTLE      = 4;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid;
  logic                               in_stall;
  srpg_pkg::req_t                     in_req;
  logic                               out_valid;
  logic                               out_stall;
  srpg_pkg::rsp_t                     out_rsp;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [srpg_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [srpg_pkg::CFG_DATA_BITS-1:0] pwdata;
  logic [srpg_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                               pready;
  int unsigned                        pending;
  int unsigned                        errors;

  int unsigned requests_sent = 0;
  int unsigned tx_total      = 0;
  bit          tx_calm       = 1'b0;
  bit          move_live     = 1'b0;
  int unsigned eff_len       = 1600;
  int unsigned ramp_settings [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stepper_ramp_profile_generator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  srpg_profile_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  function automatic srpg_pkg::req_t rand_req(input logic [1:0] c);
    srpg_pkg::req_t r;
    r.cmd         = c;
    r.table_index = 11'($urandom_range(0, 2047));
    r.table_value = 16'($urandom_range(0, 65535));
    r.pulse_count = 24'($urandom_range(0, 24'hffffff));
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(input srpg_pkg::req_t r, input bit counted);
    int unsigned gap;
    if (tx_total % 64 == 0) tx_calm = ($urandom_range(0, 2) == 0);
    tx_total++;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (counted) requests_sent++;
  endtask

  task automatic put_entry(input int unsigned idx, input int unsigned val);
    srpg_pkg::req_t r;
    r = rand_req(srpg_pkg::CMD_WRITE);
    r.table_index = 11'(idx);
    r.table_value = 16'(val);
    push_request(r, 1'b1);
  endtask

  task automatic start_move(input int unsigned n);
    srpg_pkg::req_t r;
    r = rand_req(srpg_pkg::CMD_START);
    r.pulse_count = 24'(n);
    push_request(r, 1'b1);
  endtask

  task automatic tick(input bit counted);
    push_request(rand_req(srpg_pkg::CMD_TICK), counted);
  endtask

  // keeps every table read inside the preloaded prefix
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return $urandom_range(0, 3);
    if (r < 12) return $urandom_range(0, 40);
    if (eff_len <= PRELOAD && r < 17)
      return 2 * eff_len + $urandom_range(0, 24) - $urandom_range(0, 2);
    return $urandom_range(41, 2 * PRELOAD + 1);
  endfunction

  task automatic run_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    kind = $urandom_range(0, 19);
    if (kind < 12) begin
      n = pick_count();
      start_move(n);
      for (int unsigned i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) put_entry($urandom_range(0, 2047), $urandom_range(0, 65535));
        tick(1'b1);
      end
      move_live = 1'b0;
    end else if (kind < 16) begin
      case ($urandom_range(0, 2))
        0:       n = 24'hffffff;
        1:       n = $urandom_range(0, 24'hffffff);
        default: n = $urandom_range(1, 60);
      endcase
      start_move(n);
      k = $urandom_range(0, 10);
      for (int unsigned i = 0; i < k; i++) tick(i <= n);
      move_live = (k < n);
    end else if (kind < 18) begin
      repeat ($urandom_range(1, 4)) put_entry($urandom_range(0, 2047), $urandom_range(0, 65535));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        if (!move_live && $urandom_range(0, 1) == 0) tick(1'b0);
        else push_request(rand_req(CMD_UNUSED), 1'b0);
      end
    end
  endtask

  task automatic run_phase();
    int unsigned first;
    first = requests_sent;
    while (requests_sent - first < PHASE_ITEMS) run_sequence();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // write, then read back in the next transfer
  task automatic set_ramp_length(input logic [srpg_pkg::LEN_BITS-1:0] len);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= srpg_pkg::REG_RAMP_LENGTH;
    pwdata  <= ($urandom() & 32'hfffff000) | srpg_pkg::CFG_DATA_BITS'(len);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    eff_len = (len == '0) ? 1 : ((len > 2048) ? 2048 : int'(len));
  endtask

  // result side: random pause per result, two long hold-offs
  initial begin : result_side
    int unsigned wait_left;
    int unsigned taken;
    bit          calm;
    out_stall = 1'b0;
    wait_left = 0;
    taken     = 0;
    calm      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && !out_stall) begin
        taken++;
        if (taken % 80 == 0) calm = ($urandom_range(0, 2) == 0);
        if (taken == 150 || taken == 900) wait_left = 300;
        else wait_left = calm ? 0 : $urandom_range(0, 4);
      end
      @(negedge clk_i);
      out_stall <= (wait_left != 0);
      if (wait_left != 0) wait_left--;
    end
  end

  initial begin : watchdog
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    ramp_settings = '{1, 2048, 0, 4095, 2, 3, 16, 0};
    ramp_settings[7] = $urandom_range(4, PRELOAD);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < PRELOAD; i++) put_entry(i, $urandom_range(0, 65535));

    // directed
    put_entry(2047, 16'hffff);
    put_entry(1, 16'hffff);
    put_entry(0, 16'h0000);
    start_move(0);
    tick(1'b0);
    push_request(rand_req(CMD_UNUSED), 1'b0);
    start_move(1);
    tick(1'b1);
    start_move(2);
    repeat (2) tick(1'b1);
    start_move(3);
    repeat (3) tick(1'b1);
    start_move(24'hffffff);
    repeat (2) tick(1'b1);
    start_move(5);
    repeat (5) tick(1'b1);
    tick(1'b0);

    run_phase();
    foreach (ramp_settings[i]) begin
      settle();
      set_ramp_length(srpg_pkg::LEN_BITS'(ramp_settings[i]));
      move_live = 1'b0;
      run_phase();
    end
    settle();

    if (errors == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
